/* src/pst_pkg.sv */
// Shared types, codes and keyword table for the Pascal-subset tokenizer.
`default_nettype none
package pst_pkg;

	localparam int PREFIX_DEPTH = 7;
	localparam int PW           = $clog2(PREFIX_DEPTH);
	localparam int KW_TOTAL     = 15;
	localparam int KW_BITS      = PREFIX_DEPTH * 8;
	localparam int QDEPTH       = 4;
	localparam int QPW          = $clog2(QDEPTH);

	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0A;

	typedef enum logic [2:0] {
		M_IDLE, M_IDENT, M_NUMBER, M_BAR, M_AMP, M_LT, M_GT, M_COLON
	} mode_t;

	typedef enum logic [3:0] {
		TC_IDENT, TC_KEYWORD, TC_NUMBER, TC_ADD, TC_REL, TC_MUL, TC_SEMI, TC_PERIOD,
		TC_ASSIGN, TC_COLON, TC_COMMA, TC_LPAREN, TC_RPAREN, TC_END, TC_ERROR
	} tok_class_t;

	localparam logic [3:0] OP_PLUS  = 4'd0;
	localparam logic [3:0] OP_MINUS = 4'd1;
	localparam logic [3:0] OP_OR    = 4'd2;
	localparam logic [3:0] OP_EQ    = 4'd3;
	localparam logic [3:0] OP_NE    = 4'd4;
	localparam logic [3:0] OP_LE    = 4'd5;
	localparam logic [3:0] OP_LT    = 4'd6;
	localparam logic [3:0] OP_GT    = 4'd7;
	localparam logic [3:0] OP_GE    = 4'd8;
	localparam logic [3:0] OP_MUL   = 4'd9;
	localparam logic [3:0] OP_DIV   = 4'd10;
	localparam logic [3:0] OP_MOD   = 4'd11;
	localparam logic [3:0] OP_AND   = 4'd12;

	typedef struct packed {
		tok_class_t  cls;
		logic [3:0]  kw;
		logic [3:0]  op;
		logic [4:0]  len;
		logic        last;
	} tok_t;

	typedef struct packed {
		logic [1:0] n;
		tok_t       t0;
		tok_t       t1;
	} push_t;

	typedef struct packed {
		logic       hit;
		logic [3:0] idx;
	} kw_res_t;

	// first character in the top byte, zero padded
	localparam logic [KW_BITS-1:0] KW_TABLE [KW_TOTAL] = '{
		"program",
		{"var", 32'd0},
		"integer",
		{"char", 24'd0},
		{"begin", 16'd0},
		{"if", 40'd0},
		{"then", 24'd0},
		{"else", 24'd0},
		{"while", 16'd0},
		{"do", 40'd0},
		{"read", 24'd0},
		{"readln", 8'd0},
		{"write", 16'd0},
		"writeln",
		{"end", 32'd0}
	};

	function automatic tok_t mk_tok(input tok_class_t cls, input logic [3:0] op);
		tok_t t;
		t     = '0;
		t.cls = cls;
		t.op  = op;
		return t;
	endfunction

endpackage
`default_nettype wire

/* src/pst_char_if.sv */
// Character input channel: valid/ready with character payload.
`default_nettype none
interface pst_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       end_of_text;

	modport source (output valid, output char_code, output end_of_text, input ready);
	modport sink (input valid, input char_code, input end_of_text, output ready);
endinterface
`default_nettype wire

/* src/pst_tok_if.sv */
// Token output channel: valid/ready with token payload.
`default_nettype none
interface pst_tok_if;
	logic       valid;
	logic       ready;
	logic [3:0] token_class;
	logic [3:0] keyword_index;
	logic [3:0] operator_kind;
	logic [4:0] lexeme_length;
	logic       last_in_run;

	modport source (output valid, output token_class, output keyword_index,
		output operator_kind, output lexeme_length, output last_in_run, input ready);
	modport sink (input valid, input token_class, input keyword_index,
		input operator_kind, input lexeme_length, input last_in_run, output ready);
endinterface
`default_nettype wire

/* src/pst_kwmatch.sv */
// Parallel keyword compare of the buffered word prefix against the fixed table.
`default_nettype none
module pst_kwmatch import pst_pkg::*; #(
	parameter int KEYWORD_COUNT = 15,
	parameter int CW            = 5
) (
	input  logic [PREFIX_DEPTH-1:0][7:0] prefix,
	input  logic [CW-1:0]                count,
	output kw_res_t                      kw
);

	logic [KW_BITS-1:0] word;
	logic               eligible;

	always_comb begin
		for (int j = 0; j < PREFIX_DEPTH; j++) begin
			word[KW_BITS-1-8*j -: 8] = (CW'(j) < count) ? prefix[j] : 8'd0;
		end
	end

	assign eligible = (count <= CW'(PREFIX_DEPTH));

	always_comb begin
		kw = '0;
		for (int i = KW_TOTAL - 1; i >= 0; i--) begin
			if (i < KEYWORD_COUNT && eligible && word == KW_TABLE[i]) begin
				kw.hit = 1'b1;
				kw.idx = 4'(i);
			end
		end
	end

endmodule
`default_nettype wire

/* src/pst_lexer.sv */
// Input register, scanner state and token generation for one character.
`default_nettype none
module pst_lexer import pst_pkg::*; #(
	parameter int LEXEME_MAX = 29,
	parameter int CW         = 5
) (
	input  logic                        clk,
	input  logic                        arst_n,
	pst_char_if.sink                    chars,
	input  logic                        room,
	input  kw_res_t                     kw,
	output logic [PREFIX_DEPTH-1:0][7:0] prefix,
	output logic [CW-1:0]               count,
	output push_t                       push
);

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       eot_s1;
	logic       advance;

	mode_t                        mode_q, mode_n;
	logic [CW-1:0]                cnt_q, cnt_n;
	logic [PREFIX_DEPTH-1:0][7:0] prefix_q;
	logic                         wr_en;
	logic [PW-1:0]                wr_idx;

	logic  is_let, is_dig;
	tok_t  word_tok;
	logic  idle_v, idle_start;
	tok_t  idle_tok;
	mode_t idle_mode;
	logic  first_v, sec_v, use_idle, app;
	tok_t  first_tok, sec_tok;

	assign advance     = valid_s1 & room;
	assign chars.ready = ~valid_s1 | room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			char_s1 <= chars.char_code;
			eot_s1  <= chars.end_of_text;
		end
	end

	assign is_let = (char_s1 >= "a" && char_s1 <= "z") || (char_s1 >= "A" && char_s1 <= "Z");
	assign is_dig = (char_s1 >= "0" && char_s1 <= "9");

	always_comb begin
		word_tok     = '0;
		word_tok.len = 5'(cnt_q);
		if (mode_q == M_NUMBER) begin
			word_tok.cls = TC_NUMBER;
		end else if (kw.hit) begin
			word_tok.cls = TC_KEYWORD;
			word_tok.kw  = kw.idx;
		end else begin
			word_tok.cls = TC_IDENT;
		end
	end

	// character seen from the idle state
	always_comb begin
		idle_v     = 1'b1;
		idle_tok   = mk_tok(TC_END, OP_PLUS);
		idle_mode  = M_IDLE;
		idle_start = 1'b0;
		if (is_let) begin
			idle_v     = 1'b0;
			idle_mode  = M_IDENT;
			idle_start = 1'b1;
		end else if (is_dig) begin
			idle_v     = 1'b0;
			idle_mode  = M_NUMBER;
			idle_start = 1'b1;
		end else begin
			case (char_s1)
				" ", CH_TAB, CH_LF: idle_v = 1'b0;
				";": idle_tok = mk_tok(TC_SEMI, OP_PLUS);
				".": idle_tok = mk_tok(TC_PERIOD, OP_PLUS);
				",": idle_tok = mk_tok(TC_COMMA, OP_PLUS);
				"(": idle_tok = mk_tok(TC_LPAREN, OP_PLUS);
				")": idle_tok = mk_tok(TC_RPAREN, OP_PLUS);
				"+": idle_tok = mk_tok(TC_ADD, OP_PLUS);
				"-": idle_tok = mk_tok(TC_ADD, OP_MINUS);
				"=": idle_tok = mk_tok(TC_REL, OP_EQ);
				"*": idle_tok = mk_tok(TC_MUL, OP_MUL);
				"/": idle_tok = mk_tok(TC_MUL, OP_DIV);
				"%": idle_tok = mk_tok(TC_MUL, OP_MOD);
				":": begin
					idle_v    = 1'b0;
					idle_mode = M_COLON;
				end
				"<": begin
					idle_v    = 1'b0;
					idle_mode = M_LT;
				end
				">": begin
					idle_v    = 1'b0;
					idle_mode = M_GT;
				end
				"|": begin
					idle_v    = 1'b0;
					idle_mode = M_BAR;
				end
				"&": begin
					idle_v    = 1'b0;
					idle_mode = M_AMP;
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		first_v   = 1'b0;
		first_tok = word_tok;
		use_idle  = 1'b0;
		app       = 1'b0;
		mode_n    = mode_q;
		cnt_n     = cnt_q;
		wr_en     = 1'b0;
		wr_idx    = '0;
		if (eot_s1) begin
			mode_n = M_IDLE;
			cnt_n  = '0;
			case (mode_q)
				M_IDENT, M_NUMBER: first_v = 1'b1;
				M_BAR, M_AMP: begin
					first_v   = 1'b1;
					first_tok = mk_tok(TC_ERROR, OP_PLUS);
				end
				M_LT: begin
					first_v   = 1'b1;
					first_tok = mk_tok(TC_REL, OP_LT);
				end
				M_GT: begin
					first_v   = 1'b1;
					first_tok = mk_tok(TC_REL, OP_GT);
				end
				M_COLON: begin
					first_v   = 1'b1;
					first_tok = mk_tok(TC_COLON, OP_PLUS);
				end
				default: ;
			endcase
		end else begin
			case (mode_q)
				M_IDENT: begin
					if (is_let || is_dig) begin
						app = 1'b1;
					end else begin
						first_v  = 1'b1;
						use_idle = 1'b1;
					end
				end
				M_NUMBER: begin
					if (is_dig) begin
						app = 1'b1;
					end else begin
						first_v  = 1'b1;
						use_idle = 1'b1;
					end
				end
				M_BAR: begin
					first_v = 1'b1;
					mode_n  = M_IDLE;
					if (char_s1 == "|") begin
						first_tok = mk_tok(TC_ADD, OP_OR);
					end else begin
						first_tok = mk_tok(TC_ERROR, OP_PLUS);
						use_idle  = 1'b1;
					end
				end
				M_AMP: begin
					first_v = 1'b1;
					mode_n  = M_IDLE;
					if (char_s1 == "&") begin
						first_tok = mk_tok(TC_MUL, OP_AND);
					end else begin
						first_tok = mk_tok(TC_ERROR, OP_PLUS);
						use_idle  = 1'b1;
					end
				end
				M_LT: begin
					first_v = 1'b1;
					mode_n  = M_IDLE;
					if (char_s1 == ">") begin
						first_tok = mk_tok(TC_REL, OP_NE);
					end else if (char_s1 == "=") begin
						first_tok = mk_tok(TC_REL, OP_LE);
					end else begin
						first_tok = mk_tok(TC_REL, OP_LT);
						use_idle  = 1'b1;
					end
				end
				M_GT: begin
					first_v = 1'b1;
					mode_n  = M_IDLE;
					if (char_s1 == "=") begin
						first_tok = mk_tok(TC_REL, OP_GE);
					end else begin
						first_tok = mk_tok(TC_REL, OP_GT);
						use_idle  = 1'b1;
					end
				end
				M_COLON: begin
					first_v = 1'b1;
					mode_n  = M_IDLE;
					if (char_s1 == "=") begin
						first_tok = mk_tok(TC_ASSIGN, OP_PLUS);
					end else begin
						first_tok = mk_tok(TC_COLON, OP_PLUS);
						use_idle  = 1'b1;
					end
				end
				default: use_idle = 1'b1;
			endcase
		end
		if (use_idle) begin
			mode_n = idle_mode;
			if (idle_start) begin
				cnt_n  = CW'(1);
				wr_en  = 1'b1;
				wr_idx = '0;
			end
		end
		if (app) begin
			if (cnt_q < CW'(PREFIX_DEPTH)) begin
				wr_en  = 1'b1;
				wr_idx = cnt_q[PW-1:0];
			end
			if (cnt_q < CW'(LEXEME_MAX)) begin
				cnt_n = cnt_q + CW'(1);
			end
		end
	end

	always_comb begin
		sec_v   = eot_s1 | (use_idle & idle_v);
		sec_tok = eot_s1 ? mk_tok(TC_END, OP_PLUS) : idle_tok;
		push    = '0;
		if (first_v) begin
			push.t0 = first_tok;
			push.t1 = sec_tok;
			push.n  = sec_v ? 2'd2 : 2'd1;
		end else begin
			push.t0 = sec_tok;
			push.n  = sec_v ? 2'd1 : 2'd0;
		end
		if (push.n == 2'd2) begin
			push.t1.last = 1'b1;
		end else begin
			push.t0.last = 1'b1;
		end
		if (!advance) begin
			push.n = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			cnt_q  <= '0;
		end else if (advance) begin
			mode_q <= mode_n;
			cnt_q  <= cnt_n;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && wr_en) begin
			prefix_q[wr_idx] <= char_s1;
		end
	end

	assign prefix = prefix_q;
	assign count  = cnt_q;

`ifndef ASSERT_OFF
	a_eot_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && eot_s1 |=> mode_q == M_IDLE && cnt_q == '0)
		else $error("state not cleared after end of text");
	a_last_mark: assert property (@(posedge clk) disable iff (!arst_n)
		push.n == 2'd2 |-> push.t1.last && !push.t0.last)
		else $error("last_in_run on wrong token of a pair");
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !room |=> valid_s1 && $stable(char_s1) && $stable(eot_s1))
		else $error("input register lost a stalled character");
`endif

endmodule
`default_nettype wire

/* src/pst_outq.sv */
// Four-entry token queue: takes up to two tokens per cycle, hands out one.
`default_nettype none
module pst_outq import pst_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  push_t      push,
	output logic       room,
	pst_tok_if.source  tokens
);

	tok_t             mem_q [QDEPTH];
	logic [QPW-1:0]   head_q, tail_q;
	logic [QPW:0]     cnt_q;
	logic             pop;
	tok_t             head_tok;

	assign pop  = tokens.valid & tokens.ready;
	assign room = (cnt_q <= (QPW+1)'(QDEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[tail_q] <= push.t0;
		end
		if (push.n == 2'd2) begin
			mem_q[tail_q + QPW'(1)] <= push.t1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (pop) begin
				head_q <= head_q + QPW'(1);
			end
			tail_q <= tail_q + QPW'(push.n);
			cnt_q  <= cnt_q + (QPW+1)'(push.n) - (QPW+1)'(pop);
		end
	end

	assign head_tok             = mem_q[head_q];
	assign tokens.valid         = (cnt_q != '0);
	assign tokens.token_class   = head_tok.cls;
	assign tokens.keyword_index = head_tok.kw;
	assign tokens.operator_kind = head_tok.op;
	assign tokens.lexeme_length = head_tok.len;
	assign tokens.last_in_run   = head_tok.last;

`ifndef ASSERT_OFF
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (QPW+1)'(QDEPTH))
		else $error("token queue overflow");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.n != 2'd0 |-> cnt_q <= (QPW+1)'(QDEPTH - 2))
		else $error("push without room");
	a_cnt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		push.n == 2'd0 && !pop |=> $stable(cnt_q))
		else $error("queue count moved without a transfer");
`endif

endmodule
`default_nettype wire

/* src/pascal_subset_tokenizer.sv */
// A character's first token passes the input register, then the token queue, before output.
// Throughput: one character per cycle; a character that makes two tokens enqueues both
// at once, and input stalls while the four-entry token queue holds more than two.
// Reset (arst_n low): scanner returns to idle with zero count, queue empties; the word
// prefix buffer is not cleared and needs no clearing pass.
`default_nettype none
module pascal_subset_tokenizer import pst_pkg::*; #(
	parameter int LEXEME_MAX    = 29,
	parameter int KEYWORD_COUNT = 15
) (
	input  logic      clk,
	input  logic      arst_n,
	pst_char_if.sink  chars,
	pst_tok_if.source tokens
);

	localparam int CW = $clog2(LEXEME_MAX + 1);

	logic [PREFIX_DEPTH-1:0][7:0] prefix;
	logic [CW-1:0]                count;
	kw_res_t                      kw;
	push_t                        push;
	logic                         room;

	pst_lexer #(
		.LEXEME_MAX (LEXEME_MAX),
		.CW         (CW)
	) u_lexer (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars),
		.room   (room),
		.kw     (kw),
		.prefix (prefix),
		.count  (count),
		.push   (push)
	);

	pst_kwmatch #(
		.KEYWORD_COUNT (KEYWORD_COUNT),
		.CW            (CW)
	) u_kwmatch (
		.prefix (prefix),
		.count  (count),
		.kw     (kw)
	);

	pst_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.tokens (tokens)
	);

endmodule
`default_nettype wire
